FILE: src/magnetometer_median_ema_filter_defines.svh
// assertion macros for the magnetometer filter checker
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef MAGNETOMETER_MEDIAN_EMA_FILTER_DEFINES_SVH
`define MAGNETOMETER_MEDIAN_EMA_FILTER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MMEF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define MMEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mmef_pkg.sv
// shared types, constants and helpers of the magnetometer median/ema filter
// no dependencies
`default_nettype none

package mmef_pkg;

  localparam int unsigned SensorCountDef = 8;
  localparam int unsigned SensWideW      = 7;
  localparam int unsigned WindowLen      = 3;
  localparam int unsigned NumAxes        = 3;
  localparam int unsigned SensorW        = 3;
  localparam int unsigned StatusW        = 8;
  localparam int unsigned RawW           = 16;
  localparam int unsigned GainW          = 16;
  localparam int unsigned ShiftW         = 3;
  localparam int unsigned FieldW         = 24;
  localparam int unsigned ScaleShift     = 8;
  localparam int unsigned ProdW          = RawW + GainW + 1;
  localparam int unsigned SlotW          = 2;
  localparam int unsigned ErrCntW        = 16;
  localparam int unsigned GoodCntW       = 32;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 16;

  localparam logic [StatusW-1:0] StatusErrMask = 8'h10;
  localparam logic [StatusW-1:0] StatusSatMask = 8'h60;

  localparam logic [GainW-1:0]  GainXyRst = 16'd9830;
  localparam logic [GainW-1:0]  GainZRst  = 16'd15860;
  localparam logic [ShiftW-1:0] ShiftRst  = 3'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_XY      = 2'd0,
    CFG_GAIN_Z       = 2'd1,
    CFG_SMOOTH_SHIFT = 2'd2
  } cfg_idx_e;

  typedef logic signed [FieldW-1:0] field_t;
  typedef logic [FieldW-1:0] field_bits_t;
  typedef field_bits_t [WindowLen-1:0] ring_t;
  typedef ring_t [NumAxes-1:0] med_row_t;
  typedef field_bits_t [NumAxes-1:0] filt_row_t;

  // raw reading as held in the input register
  typedef struct packed {
    logic [SensorW-1:0] sensor;
    logic [StatusW-1:0] status;
    logic [RawW-1:0]    x_raw;
    logic [RawW-1:0]    y_raw;
    logic [RawW-1:0]    z_raw;
  } raw_t;

  // scaled reading handed from the scaling stage to the filter core
  typedef struct packed {
    logic [SensorW-1:0] sensor;
    logic               dropped;
    logic               sat;
    filt_row_t          scaled;
  } scaled_t;

  // one result item
  typedef struct packed {
    logic [SensorW-1:0]  sensor;
    filt_row_t           field;
    logic                read_error;
    logic                saturated;
    logic [ErrCntW-1:0]  error_total;
    logic [GoodCntW-1:0] good_total;
  } result_t;

  // median of three signed values
  function automatic field_t median3(field_t a, field_t b, field_t c);
    field_t lo;
    field_t hi;
    field_t hic;
    lo  = (a < b) ? a : b;
    hi  = (a < b) ? b : a;
    hic = (hi < c) ? hi : c;
    return (lo > hic) ? lo : hic;
  endfunction

endpackage

`default_nettype wire

FILE: src/mmef_scale.sv
// scaling stage: raw samples times gain, floor shift to Q.8 microtesla
// depends on mmef_pkg
`default_nettype none

module mmef_scale import mmef_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire raw_t             raw_i,
  input  wire logic [GainW-1:0] gain_xy_i,
  input  wire logic [GainW-1:0] gain_z_i,
  output scaled_t               scaled_o
);

  logic signed [ProdW-1:0] prod_x;
  logic signed [ProdW-1:0] prod_y;
  logic signed [ProdW-1:0] prod_z;
  scaled_t                 scaled_d;
  scaled_t                 scaled_q;

  // one multiplier per axis, floor shift is a plain arithmetic select
  assign prod_x = $signed(raw_i.x_raw) * $signed({1'b0, gain_xy_i});
  assign prod_y = $signed(raw_i.y_raw) * $signed({1'b0, gain_xy_i});
  assign prod_z = $signed(raw_i.z_raw) * $signed({1'b0, gain_z_i});

  always_comb begin
    scaled_d.sensor    = raw_i.sensor;
    scaled_d.dropped   = |(raw_i.status & StatusErrMask);
    scaled_d.sat       = |(raw_i.status & StatusSatMask);
    scaled_d.scaled[0] = prod_x[FieldW+ScaleShift-1:ScaleShift];
    scaled_d.scaled[1] = prod_y[FieldW+ScaleShift-1:ScaleShift];
    scaled_d.scaled[2] = prod_z[FieldW+ScaleShift-1:ScaleShift];
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      scaled_q <= scaled_d;
    end
  end

  assign scaled_o = scaled_q;

endmodule

`default_nettype wire

FILE: src/mmef_core.sv
// filter core: per-sensor median ring, ema, counters and the result register
// depends on mmef_pkg
`default_nettype none

module mmef_core import mmef_pkg::*; #(
  parameter int unsigned SENSOR_COUNT = SensorCountDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire scaled_t           scaled_i,
  input  wire logic [ShiftW-1:0] smooth_shift_i,
  output result_t                result_o
);

  localparam int unsigned SidxW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  med_row_t              med_q  [SENSOR_COUNT];
  filt_row_t             filt_q [SENSOR_COUNT];
  logic [SlotW-1:0]      slot_q [SENSOR_COUNT];
  logic [ErrCntW-1:0]    err_q  [SENSOR_COUNT];
  logic [GoodCntW-1:0]   good_q [SENSOR_COUNT];

  logic [SensWideW-1:0]  sens_wide;
  logic [SidxW-1:0]      idx;
  logic [SlotW-1:0]      slot_cur;
  logic [SlotW-1:0]      slot_use;
  logic [SlotW-1:0]      slot_d;
  med_row_t              med_d;
  filt_row_t             filt_d;
  logic [ErrCntW-1:0]    err_cur;
  logic [ErrCntW-1:0]    err_d;
  logic [GoodCntW-1:0]   good_cur;
  logic [GoodCntW-1:0]   good_d;
  result_t               result_d;
  result_t               result_q;

  assign sens_wide = SensWideW'(scaled_i.sensor);
  assign idx       = sens_wide[SidxW-1:0];
  assign slot_cur  = slot_q[idx];
  assign slot_use  = (slot_cur >= SlotW'(WindowLen)) ? '0 : slot_cur;
  assign slot_d    = (slot_use == SlotW'(WindowLen - 1)) ? '0 : slot_use + 1'b1;
  assign err_cur   = err_q[idx];
  assign good_cur  = good_q[idx];

  // saturating counters
  assign err_d  = (&err_cur)  ? err_cur  : err_cur + 1'b1;
  assign good_d = (&good_cur) ? good_cur : good_cur + 1'b1;

  // ring update, median and ema step, all axes in parallel
  always_comb begin
    ring_t                   ring;
    field_t                  med;
    logic signed [FieldW:0]  prev_w;
    logic signed [FieldW:0]  diff;
    logic signed [FieldW:0]  step;
    logic signed [FieldW:0]  next_w;
    med_d  = med_q[idx];
    filt_d = filt_q[idx];
    for (int a = 0; a < NumAxes; a++) begin
      ring           = med_d[a];
      ring[slot_use] = scaled_i.scaled[a];
      med_d[a]       = ring;
      med            = median3($signed(ring[0]), $signed(ring[1]), $signed(ring[2]));
      prev_w         = $signed({filt_d[a][FieldW-1], filt_d[a]});
      diff           = $signed({med[FieldW-1], med}) - prev_w;
      step           = diff >>> smooth_shift_i;
      next_w         = prev_w + step;
      filt_d[a]      = next_w[FieldW-1:0];
    end
  end

  // result item: dropped readings report the stored values
  always_comb begin
    result_d.sensor = scaled_i.sensor;
    if (scaled_i.dropped) begin
      result_d.field       = filt_q[idx];
      result_d.read_error  = 1'b1;
      result_d.saturated   = 1'b0;
      result_d.error_total = err_d;
      result_d.good_total  = good_cur;
    end else begin
      result_d.field       = filt_d;
      result_d.read_error  = 1'b0;
      result_d.saturated   = scaled_i.sat;
      result_d.error_total = err_cur;
      result_d.good_total  = good_d;
    end
  end

  // per-sensor state, written when the result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        med_q[s]  <= '0;
        filt_q[s] <= '0;
        slot_q[s] <= '0;
        err_q[s]  <= '0;
        good_q[s] <= '0;
      end
    end else if (load_i) begin
      if (scaled_i.dropped) begin
        err_q[idx] <= err_d;
      end else begin
        med_q[idx]  <= med_d;
        filt_q[idx] <= filt_d;
        slot_q[idx] <= slot_d;
        good_q[idx] <= good_d;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

FILE: src/magnetometer_median_ema_filter.sv
// A reading passes the input register on its transfer edge, then the scaling register,
// then the result register, which shows its result.
// Throughput: one reading per cycle unless the output stalls; per-sensor state is written
// when the result register loads, so the next reading of the same sensor already sees it.
// Reset: clears all per-sensor state and valid bits, loads register defaults.
// top level: config registers and handshake control; uses mmef_pkg, mmef_scale, mmef_core
`default_nettype none

module magnetometer_median_ema_filter import mmef_pkg::*; #(
  parameter int unsigned SENSOR_COUNT = SensorCountDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic [SensorW-1:0]  sensor_index_i,
  input  wire logic [StatusW-1:0]  status_byte_i,
  input  wire logic signed [RawW-1:0] x_raw_i,
  input  wire logic signed [RawW-1:0] y_raw_i,
  input  wire logic signed [RawW-1:0] z_raw_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      logic [SensorW-1:0]  sensor_out_o,
  output      logic signed [FieldW-1:0] field_x_o,
  output      logic signed [FieldW-1:0] field_y_o,
  output      logic signed [FieldW-1:0] field_z_o,
  output      logic                read_error_o,
  output      logic                saturated_o,
  output      logic [ErrCntW-1:0]  error_total_o,
  output      logic [GoodCntW-1:0] good_total_o
);

  logic [GainW-1:0]  gain_xy_q;
  logic [GainW-1:0]  gain_z_q;
  logic [ShiftW-1:0] shift_q;

  logic    v1_q, v2_q, v3_q;
  logic    adv1, adv2, adv3;
  logic    sens_ok;
  raw_t    raw_d;
  raw_t    raw_q;
  scaled_t scaled;
  result_t result;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_xy_q <= GainXyRst;
      gain_z_q  <= GainZRst;
      shift_q   <= ShiftRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GAIN_XY:      gain_xy_q <= cfg_wdata_i[GainW-1:0];
        CFG_GAIN_Z:       gain_z_q  <= cfg_wdata_i[GainW-1:0];
        CFG_SMOOTH_SHIFT: shift_q   <= cfg_wdata_i[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  // stall chain, each stage moves when the one after it has room
  assign adv3       = !v3_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  // readings of sensors beyond the array are taken and discarded
  assign sens_ok = SensWideW'(sensor_index_i) < SensWideW'(SENSOR_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i && sens_ok;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  assign raw_d = '{sensor: sensor_index_i, status: status_byte_i,
                   x_raw: x_raw_i, y_raw: y_raw_i, z_raw: z_raw_i};

  // input register
  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      raw_q <= raw_d;
    end
  end

  mmef_scale u_scale (
    .clk_i     (clk_i),
    .load_i    (adv2 && v1_q),
    .raw_i     (raw_q),
    .gain_xy_i (gain_xy_q),
    .gain_z_i  (gain_z_q),
    .scaled_o  (scaled)
  );

  mmef_core #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (adv3 && v2_q),
    .scaled_i       (scaled),
    .smooth_shift_i (shift_q),
    .result_o       (result)
  );

  assign out_valid_o   = v3_q;
  assign sensor_out_o  = result.sensor;
  assign field_x_o     = $signed(result.field[0]);
  assign field_y_o     = $signed(result.field[1]);
  assign field_z_o     = $signed(result.field[2]);
  assign read_error_o  = result.read_error;
  assign saturated_o   = result.saturated;
  assign error_total_o = result.error_total;
  assign good_total_o  = result.good_total;

endmodule

`default_nettype wire

FILE: src/mmef_checker.sv
// port-level checker for the magnetometer filter, bound to the top level
// depends on mmef_pkg and the assertion macro header
`default_nettype none
`include "magnetometer_median_ema_filter_defines.svh"

module mmef_checker import mmef_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic [SensorW-1:0]  sensor_out_o,
  input wire logic signed [FieldW-1:0] field_x_o,
  input wire logic                read_error_o,
  input wire logic                saturated_o,
  input wire logic [ErrCntW-1:0]  error_total_o,
  input wire logic [GoodCntW-1:0] good_total_o
);

  // a stalled result holds
  `MMEF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(sensor_out_o) && $stable(field_x_o), "stalled result changed")

  // a dropped reading never reports saturation
  `MMEF_ASSERT_NOW(a_drop_no_sat, out_valid_o && read_error_o, !saturated_o,
    "dropped reading flagged saturated")

  // a dropped reading has been counted
  `MMEF_ASSERT_NOW(a_drop_counted, out_valid_o && read_error_o, error_total_o != '0,
    "dropped reading with zero error count")

  // a good reading has been counted
  `MMEF_ASSERT_NOW(a_good_counted, out_valid_o && !read_error_o, good_total_o != '0,
    "good reading with zero good count")

endmodule

bind magnetometer_median_ema_filter mmef_checker u_mmef_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sensor_out_o (sensor_out_o),
  .field_x_o    (field_x_o),
  .read_error_o (read_error_o),
  .saturated_o  (saturated_o),
  .error_total_o(error_total_o),
  .good_total_o (good_total_o)
);

`default_nettype wire
